// ----- hw/rtl/mdp_pkg.sv -----
package mdp_pkg;

  localparam int RowLen    = 8;
  localparam int CntW      = $clog2(RowLen + 1);

  localparam int WordW     = 13;
  localparam int ExpW      = 6;
  localparam int FracW     = 6;
  localparam int MantW     = 14;
  localparam int ShW       = 7;
  localparam int AccW      = 80;
  localparam int AccFrac   = 44;

  localparam int ExpOffset = 32;
  localparam int ExpTop    = 63;
  localparam int WinMin    = 16;
  localparam int WinMax    = 47;

  // bit position of the leading one for the smallest and largest encodable exponent
  localparam int PMin      = AccFrac - ExpOffset;
  localparam int PMax      = PMin + ExpTop;

  localparam int FqDepth   = 4;

  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 6;

  localparam logic [CfgIdxW-1:0] RegAnchorLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegAnchorHigh = 1'b1;

  localparam logic [ExpW-1:0] AnchorLowRst  = 6'd28;
  localparam logic [ExpW-1:0] AnchorHighRst = 6'd35;

  // one classified pair: signed, shifted mantissa to add into the accumulator
  typedef struct packed {
    logic             neg;
    logic [MantW-1:0] mant;
    logic [ShW-1:0]   sh;
    logic             last;
  } fq_item_t;

endpackage

// ----- hw/rtl/mdp_front.sv -----
module mdp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mdp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mdp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         take_i,
  input  logic [mdp_pkg::WordW-1:0]    mat_elem_i,
  input  logic [mdp_pkg::WordW-1:0]    vec_elem_i,
  input  logic                         row_end_i,
  output mdp_pkg::fq_item_t            item_o
);
  import mdp_pkg::*;

  logic [ExpW-1:0] anchor_low_q, anchor_high_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic             sa, sb;
  logic [ExpW-1:0]  ea, eb, wlo, whi, es;
  logic [FracW-1:0] fa, fb, fr;
  logic [MantW-1:0] prod;
  logic [ShW-1:0]   esum_raw;
  logic [ShW:0]     esum;
  logic             exact, last;
  logic [CntW-1:0]  cnt_inc;

  function automatic logic [ExpW-1:0] clamp_win(input logic [ExpW-1:0] v);
    if (v < ExpW'(WinMin)) return ExpW'(WinMin);
    if (v > ExpW'(WinMax)) return ExpW'(WinMax);
    return v;
  endfunction

  always_comb begin
    sa   = mat_elem_i[WordW-1];
    sb   = vec_elem_i[WordW-1];
    ea   = mat_elem_i[FracW +: ExpW];
    eb   = vec_elem_i[FracW +: ExpW];
    fa   = mat_elem_i[FracW-1:0];
    fb   = vec_elem_i[FracW-1:0];
    prod = MantW'({1'b1, fa}) * MantW'({1'b1, fb});
    wlo  = clamp_win(anchor_low_q);
    whi  = clamp_win(anchor_high_q);

    exact = (ea >= wlo) && (ea <= whi) && (eb >= wlo) && (eb <= whi);

    esum_raw = ShW'(ea) + ShW'(eb);
    esum     = (ShW+1)'(esum_raw) + (ShW+1)'(prod[MantW-1]);
    fr       = prod[MantW-1] ? prod[MantW-2 -: FracW] : prod[MantW-3 -: FracW];
    es       = '0;
    priority if (esum < (ShW+1)'(ExpOffset)) begin
      es = '0;
      fr = '0;
    end else if (esum > (ShW+1)'(ExpOffset + ExpTop)) begin
      es = ExpW'(ExpTop);
      fr = '1;
    end else begin
      es = ExpW'(esum - (ShW+1)'(ExpOffset));
    end

    item_o.neg = sa ^ sb;
    if (exact) begin
      item_o.mant = prod;
      item_o.sh   = esum_raw - ShW'(ExpOffset);
    end else begin
      item_o.mant = MantW'({1'b1, fr});
      item_o.sh   = ShW'(es) + ShW'(FracW);
    end

    cnt_inc     = cnt_q + 1'b1;
    last        = row_end_i || (cnt_inc >= CntW'(RowLen));
    item_o.last = last;
    cnt_d       = last ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_low_q  <= AnchorLowRst;
      anchor_high_q <= AnchorHighRst;
      cnt_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegAnchorLow:  anchor_low_q  <= cfg_wdata_i;
          RegAnchorHigh: anchor_high_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (take_i) begin
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

// ----- hw/rtl/mdp_queue.sv -----
module mdp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mdp_pkg::fq_item_t push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output mdp_pkg::fq_item_t head_o
);
  import mdp_pkg::*;

  localparam int PtrW = $clog2(FqDepth);
  localparam int QCntW = $clog2(FqDepth + 1);

  fq_item_t mem_q [FqDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(FqDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(FqDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(FqDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(FqDepth))
    else $error("queue count past depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");
  a_push_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not grow on push");
`endif

endmodule

// ----- hw/rtl/mdp_back.sv -----
module mdp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       q_empty_i,
  input  mdp_pkg::fq_item_t          q_head_i,
  output logic                       q_pop_o,
  output logic                       res_v_o,
  output logic [mdp_pkg::AccW-1:0]   res_o
);
  import mdp_pkg::*;

  logic            b1_v_q, b1_neg_q, b1_last_q;
  logic [AccW-1:0] b1_term_q, term_d;
  logic [AccW-1:0] acc_q, sum;
  logic            res_v_q;
  logic [AccW-1:0] res_q;

  assign q_pop_o = en_i && !q_empty_i;
  assign term_d  = AccW'(q_head_i.mant) << q_head_i.sh;
  assign sum     = acc_q + (b1_term_q ^ {AccW{b1_neg_q}}) + AccW'(b1_neg_q);
  assign res_v_o = res_v_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b1_term_q <= term_d;
      b1_neg_q  <= q_head_i.neg;
      b1_last_q <= q_head_i.last;
    end
    if (en_i && b1_v_q && b1_last_q) begin
      res_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      res_v_q <= 1'b0;
      acc_q   <= '0;
    end else if (en_i) begin
      b1_v_q  <= q_pop_o;
      res_v_q <= b1_v_q && b1_last_q;
      if (b1_v_q) begin
        acc_q <= b1_last_q ? '0 : sum;
      end
    end
  end

endmodule

// ----- hw/rtl/mdp_enc.sv -----
module mdp_enc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       en_o,
  input  logic                       res_v_i,
  input  logic [mdp_pkg::AccW-1:0]   res_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [mdp_pkg::WordW-1:0]  y_word_o
);
  import mdp_pkg::*;

  localparam int NChunk = AccW / 8;
  localparam int ChW    = $clog2(NChunk);
  localparam int PW     = ChW + 3;
  localparam int ODepth = 2;
  localparam int OPtrW  = $clog2(ODepth);
  localparam int OCntW  = $clog2(ODepth + 1);

  // stage 1: magnitude
  logic            e1_v_q, e1_sgn_q;
  logic [AccW-1:0] e1_mag_q;

  // stage 2: coarse normalize to the leading nonzero byte
  logic            e2_v_q, e2_sgn_q, e2_nz_q;
  logic [ChW-1:0]  e2_c_q, c_d;
  logic [15:0]     e2_top_q, top_d;
  logic [AccW+7:0] ext;

  // final: fine position, round, pack
  logic [2:0]       j;
  logic [PW-1:0]    p;
  logic [3:0]       jp1;
  logic [7:0]       win;
  logic [FracW:0]   f;
  logic [ExpW-1:0]  e;
  logic [WordW-1:0] word, sat;

  logic [WordW-1:0] ofifo_q [ODepth];
  logic [OPtrW-1:0] owr_q, ord_q;
  logic [OCntW-1:0] ocnt_q;
  logic             opush, opop;

  assign en_o  = !(e2_v_q && (ocnt_q == OCntW'(ODepth)));
  assign opush = en_o && e2_v_q;
  assign opop  = pop_i && !empty_o;
  assign empty_o = (ocnt_q == '0);
  assign y_word_o = ofifo_q[ord_q];

  always_comb begin
    c_d = '0;
    for (int i = 0; i < NChunk; i++) begin
      if (|e1_mag_q[8*i +: 8]) c_d = ChW'(i);
    end
    ext   = {e1_mag_q, 8'h00};
    top_d = ext[{c_d, 3'b000} +: 16];
  end

  always_comb begin
    j = '0;
    for (int i = 0; i < 8; i++) begin
      if (e2_top_q[8+i]) j = 3'(i);
    end
    p   = {e2_c_q, j};
    jp1 = {1'b0, j} + 4'd1;
    win = e2_top_q[jp1 +: 8];
    f   = {1'b0, win[6:1]} + (FracW+1)'(win[0]);
    e   = ExpW'(p - PW'(PMin));
    sat = {e2_sgn_q, {ExpW{1'b1}}, {FracW{1'b1}}};
    priority if (!e2_nz_q) begin
      word = '0;
    end else if (p < PW'(PMin)) begin
      word = {e2_sgn_q, {(WordW-1){1'b0}}};
    end else if (p > PW'(PMax)) begin
      word = sat;
    end else if (f[FracW]) begin
      // rounding carried into the exponent
      word = (e == ExpW'(ExpTop)) ? sat : {e2_sgn_q, e + 1'b1, {FracW{1'b0}}};
    end else begin
      word = {e2_sgn_q, e, f[FracW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      e1_sgn_q <= res_i[AccW-1];
      e1_mag_q <= res_i[AccW-1] ? (~res_i + 1'b1) : res_i;
      e2_sgn_q <= e1_sgn_q;
      e2_nz_q  <= |e1_mag_q;
      e2_c_q   <= c_d;
      e2_top_q <= top_d;
    end
    if (opush) begin
      ofifo_q[owr_q] <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (en_o) begin
        e1_v_q <= res_v_i;
        e2_v_q <= e1_v_q;
      end
      if (opush) begin
        owr_q <= (owr_q == OPtrW'(ODepth - 1)) ? '0 : owr_q + 1'b1;
      end
      if (opop) begin
        ord_q <= (ord_q == OPtrW'(ODepth - 1)) ? '0 : ord_q + 1'b1;
      end
      ocnt_q <= ocnt_q + OCntW'(opush) - OCntW'(opop);
    end
  end

`ifndef SYNTH
  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OCntW'(ODepth))
    else $error("result queue count past depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(opush && (ocnt_q == OCntW'(ODepth))))
    else $error("push into full result queue");
  a_e1_to_e2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_o && e1_v_q) |=> e2_v_q)
    else $error("result lost between encode stages");
`endif

endmodule

// ----- hw/rtl/minifloat13_routed_dot_product.sv -----
// Path: last pair -> pair queue -> b1 -> res_q -> e1 -> e2 -> result queue (empty low).
// Throughput: one pair per cycle unless the result queue fills; the 80-bit accumulate
// loop is acc_q alone; rows of 1..8 pairs sustain this rate, with one result per cycle.
// Reset (rst_ni low, asynchronous): queues and pipeline empty, accumulator and pair count
// cleared, anchor window back to 28..35.
module minifloat13_routed_dot_product (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mdp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mdp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         push,
  output logic                         full,
  input  logic [mdp_pkg::WordW-1:0]    mat_elem_i,
  input  logic [mdp_pkg::WordW-1:0]    vec_elem_i,
  input  logic                         row_end_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [mdp_pkg::WordW-1:0]    y_word_o
);
  import mdp_pkg::*;

  fq_item_t        front_item, q_head;
  logic            take, q_empty, q_pop, en;
  logic            res_v;
  logic [AccW-1:0] res;

  assign take = push && !full;

  mdp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .mat_elem_i  (mat_elem_i),
    .vec_elem_i  (vec_elem_i),
    .row_end_i   (row_end_i),
    .item_o      (front_item)
  );

  mdp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_item_i (front_item),
    .full_o      (full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  mdp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .res_v_o   (res_v),
    .res_o     (res)
  );

  mdp_enc u_enc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_o     (en),
    .res_v_i  (res_v),
    .res_i    (res),
    .pop_i    (pop),
    .empty_o  (empty),
    .y_word_o (y_word_o)
  );

endmodule

// ----- tb/minifloat13_routed_dot_product_tb.sv -----
module minifloat13_routed_dot_product_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdp_pkg::*;

  localparam int SettleCycles = 12;
  localparam int HoldCycles   = 60;
  localparam int NumPhases    = 9;
  localparam int PhaseBeats   = 105;
  localparam int HoldPhase    = 6;
  localparam int TimeoutNs    = 400_000;
  localparam int NumDirRows   = 29;

  typedef enum logic {STIM_PAIR, STIM_CFG} stim_kind_e;

  typedef struct packed {
    stim_kind_e            kind;
    logic [WordW-1:0]      mat;
    logic [WordW-1:0]      vec;
    logic                  rend;
    logic                  typed;
    logic [WordW-1:0]      y;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   wdata;
  } stim_row_t;

  // typed y only where it is obvious; other rows go through the predictor
  localparam stim_row_t DirRows [NumDirRows] = '{
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b1, 1'b1, 13'h0800, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h1800, 13'h0800, 1'b1, 1'b1, 13'h1800, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0FFF, 13'h0FFF, 1'b1, 1'b1, 13'h0FFF, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h1FFF, 13'h0FFF, 1'b1, 1'b1, 13'h1FFF, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0000, 13'h0000, 1'b1, 1'b1, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h1000, 13'h0000, 1'b1, 1'b1, 13'h1000, RegAnchorLow, 6'd0},
    // exact cancellation
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h1800, 13'h0800, 1'b1, 1'b1, 13'h0000, RegAnchorLow, 6'd0},
    // sum past the top exponent
    '{STIM_PAIR, 13'h0FFF, 13'h0FFF, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0FFF, 13'h0FFF, 1'b1, 1'b1, 13'h0FFF, RegAnchorLow, 6'd0},
    // rounding carries into the exponent
    '{STIM_PAIR, 13'h083F, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0640, 1'b1, 1'b1, 13'h0840, RegAnchorLow, 6'd0},
    // rounding carries past the top exponent
    '{STIM_PAIR, 13'h0FFF, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0E00, 1'b1, 1'b1, 13'h0FFF, RegAnchorLow, 6'd0},
    // full row without row_end
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h0800, 13'h0800, 1'b0, 1'b1, 13'h08C0, RegAnchorLow, 6'd0},
    // anchors out of range, clamp to 16..47
    '{STIM_CFG,  13'h0000, 13'h0000, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_CFG,  13'h0000, 13'h0000, 1'b0, 1'b0, 13'h0000, RegAnchorHigh, 6'd63},
    // underflow through partial cancellation
    '{STIM_PAIR, 13'h0400, 13'h0400, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd0},
    '{STIM_PAIR, 13'h1401, 13'h0400, 1'b1, 1'b1, 13'h1000, RegAnchorLow, 6'd0},
    // empty window
    '{STIM_CFG,  13'h0000, 13'h0000, 1'b0, 1'b0, 13'h0000, RegAnchorLow, 6'd47},
    '{STIM_CFG,  13'h0000, 13'h0000, 1'b0, 1'b0, 13'h0000, RegAnchorHigh, 6'd16},
    '{STIM_PAIR, 13'h0BC0, 13'h0BC0, 1'b1, 1'b0, 13'h0000, RegAnchorLow, 6'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                push;
  logic                full;
  logic [WordW-1:0]    mat_elem_i;
  logic [WordW-1:0]    vec_elem_i;
  logic                row_end_i;
  logic                empty;
  logic                pop;
  logic [WordW-1:0]    y_word_o;

  // rides along with the beat: typed expectation for directed rows
  logic                typed_chk;
  logic [WordW-1:0]    typed_word;

  logic [AccW-1:0]     row_acc = '0;
  int                  pairs_in_row = 0;
  logic [ExpW-1:0]     anchor_lo_q = AnchorLowRst;
  logic [ExpW-1:0]     anchor_hi_q = AnchorHighRst;
  logic [WordW-1:0]    y_words_due [$];
  logic [WordW-1:0]    want_word;
  logic [WordW-1:0]    new_word;
  int                  mismatches = 0;

  int                  cur_lo = AnchorLowRst;
  int                  cur_hi = AnchorHighRst;
  bit                  calm = 1'b0;
  bit                  hold_req = 1'b0;
  logic [WordW-1:0]    prev_mat = '0;
  logic [WordW-1:0]    prev_vec = '0;

  minifloat13_routed_dot_product u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .mat_elem_i  (mat_elem_i),
    .vec_elem_i  (vec_elem_i),
    .row_end_i   (row_end_i),
    .empty       (empty),
    .pop         (pop),
    .y_word_o    (y_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int clamp_anchor(input logic [ExpW-1:0] v);
    if (int'(v) < WinMin) return WinMin;
    if (int'(v) > WinMax) return WinMax;
    return int'(v);
  endfunction

  function automatic logic [WordW-1:0] round_to_word(input logic [AccW-1:0] acc);
    logic            s;
    logic [AccW-1:0] mag;
    logic [7:0]      win;
    logic [6:0]      f;
    int              p;
    int              e;
    s   = acc[AccW-1];
    mag = s ? (~acc + 1'b1) : acc;
    if (mag == '0) return '0;
    p = 0;
    for (int i = 0; i < AccW; i++) if (mag[i]) p = i;
    if (p < PMin) return {s, 12'd0};
    if (p > PMax) return {s, 6'(ExpTop), 6'h3F};
    e   = p - PMin;
    win = 8'(mag >> (p - 7));
    f   = 7'(win[6:1]) + 7'(win[0]);
    if (f > 7'd63) begin
      f = '0;
      e++;
      if (e > ExpTop) return {s, 6'(ExpTop), 6'h3F};
    end
    return {s, 6'(e), f[5:0]};
  endfunction

  // one pair into the row sum; returns 1 with the row's word when the row closes
  function automatic bit accumulate_pair(input logic [WordW-1:0] a, input logic [WordW-1:0] b,
                                         input logic last, output logic [WordW-1:0] word);
    logic [ExpW-1:0]  ea, eb;
    logic [FracW-1:0] fr;
    logic [MantW-1:0] prod;
    logic [AccW-1:0]  term;
    int               wlo, whi, es;
    ea   = a[11:6];
    eb   = b[11:6];
    prod = (14'd64 + 14'(a[5:0])) * (14'd64 + 14'(b[5:0]));
    wlo  = clamp_anchor(anchor_lo_q);
    whi  = clamp_anchor(anchor_hi_q);
    word = '0;
    if (int'(ea) >= wlo && int'(ea) <= whi && int'(eb) >= wlo && int'(eb) <= whi) begin
      term = AccW'(prod) << (int'(ea) + int'(eb) - ExpOffset);
    end else begin
      es = int'(ea) + int'(eb) - ExpOffset;
      if (prod >= 14'd8192) begin
        es++;
        fr = prod[12:7];
      end else begin
        fr = prod[11:6];
      end
      if (es < 0) begin
        es = 0;
        fr = '0;
      end else if (es > ExpTop) begin
        es = ExpTop;
        fr = 6'h3F;
      end
      term = AccW'({1'b1, fr}) << (es + 6);
    end
    row_acc = (a[12] ^ b[12]) ? row_acc - term : row_acc + term;
    pairs_in_row++;
    if (last || pairs_in_row >= RowLen) begin
      word         = round_to_word(row_acc);
      row_acc      = '0;
      pairs_in_row = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!empty && pop) begin
        if (y_words_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected y_word %h", y_word_o);
          mismatches++;
        end else begin
          want_word = y_words_due.pop_front();
          if (y_word_o !== want_word) begin
            if (mismatches < 10) begin
              $display("y_word mismatch: expected %h got %h", want_word, y_word_o);
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegAnchorLow:  anchor_lo_q = cfg_wdata_i;
          RegAnchorHigh: anchor_hi_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (push && !full) begin
        if (accumulate_pair(mat_elem_i, vec_elem_i, row_end_i, new_word)) begin
          y_words_due.push_back(typed_chk ? typed_word : new_word);
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic put_pair(input logic [WordW-1:0] m, input logic [WordW-1:0] v,
                          input logic rend, input logic typed, input logic [WordW-1:0] y);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    push       <= 1'b1;
    mat_elem_i <= m;
    vec_elem_i <= v;
    row_end_i  <= rend;
    typed_chk  <= typed;
    typed_word <= y;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // waits for the block to go idle, then writes one anchor
  task automatic write_anchor(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    push <= 1'b0;
    while (y_words_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == RegAnchorLow) cur_lo = clamp_anchor(val);
    else cur_hi = clamp_anchor(val);
  endtask

  function automatic logic [WordW-1:0] rand_word();
    logic [ExpW-1:0]  e;
    logic [FracW-1:0] f;
    case ($urandom_range(0, 7))
      0: e = $urandom_range(0, 1) ? 6'(ExpTop) : 6'd0;
      1: e = 6'($urandom_range(0, ExpTop));
      2: e = 6'($urandom_range(cur_lo - 1, cur_lo + 1));
      3: e = 6'($urandom_range(cur_hi - 1, cur_hi + 1));
      default: e = 6'((cur_lo <= cur_hi) ? $urandom_range(cur_lo, cur_hi)
                                          : $urandom_range(WinMin - 2, WinMax + 2));
    endcase
    case ($urandom_range(0, 3))
      0: f = '0;
      1: f = 6'h3F;
      default: f = 6'($urandom);
    endcase
    return {1'($urandom_range(0, 1)), e, f};
  endfunction

  task automatic put_random(input bit force_end);
    logic [WordW-1:0] m, v;
    logic             rend;
    // sometimes the negation of the last pair, to cancel the sum
    if ($urandom_range(0, 9) == 0) begin
      m = prev_mat ^ 13'h1000;
      v = prev_vec;
    end else begin
      m = rand_word();
      v = rand_word();
    end
    rend     = force_end || ($urandom_range(0, 3) == 0);
    prev_mat = m;
    prev_vec = v;
    put_pair(m, v, rend, 1'b0, '0);
  endtask

  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] lo, hi;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegAnchorLow;
    cfg_wdata_i = '0;
    push        = 1'b0;
    mat_elem_i  = '0;
    vec_elem_i  = '0;
    row_end_i   = 1'b0;
    typed_chk   = 1'b0;
    typed_word  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NumDirRows; r++) begin
      if (DirRows[r].kind == STIM_CFG) begin
        write_anchor(DirRows[r].idx, DirRows[r].wdata);
      end else begin
        put_pair(DirRows[r].mat, DirRows[r].vec, DirRows[r].rend, DirRows[r].typed,
                 DirRows[r].y);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin lo = 6'd0;  hi = 6'd63; end
        1: begin lo = 6'd63; hi = 6'd0;  end
        2: begin lo = 6'(WinMin); hi = 6'(WinMax); end
        3: begin lo = 6'(WinMax); hi = 6'(WinMin); end
        4: begin lo = AnchorLowRst; hi = AnchorHighRst; end
        default: begin
          lo = 6'($urandom_range(10, 50));
          hi = 6'(lo + $urandom_range(0, 12));
        end
      endcase
      write_anchor(RegAnchorLow, lo);
      write_anchor(RegAnchorHigh, hi);
      calm = (ph == NumPhases - 1);
      if (ph == HoldPhase) hold_req = 1'b1;
      for (int k = 0; k < PhaseBeats; k++) begin
        put_random(ph == HoldPhase && k < 80);
      end
    end

    push <= 1'b0;
    while (y_words_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("minifloat13_routed_dot_product verification clean");
    end else begin
      $display("minifloat13_routed_dot_product verification failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("minifloat13_routed_dot_product verification failed");
    $finish;
  end

endmodule
